/* src/ehc_pkg.sv */
// ----------------------------------------------------------------------------
// ehc_pkg: shared definitions for the edge histogram classifier
// Widths, register indexes, kernel encoding and the kernel lookup function.
// ----------------------------------------------------------------------------
package ehc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int MAX_BINS   = 10;

  localparam int MEAN_W     = 16;
  localparam int THR_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int BIN_IDX_W  = 4;
  localparam int FRAC_W     = 17;

  // Address and loop counter widths for the bin store.
  localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int KW     = $clog2(MAX_BINS + 1);

  localparam int N_FIVE = (5 < MAX_BINS) ? 5 : MAX_BINS;
  localparam int N_TEN  = (10 < MAX_BINS) ? 10 : MAX_BINS;

  // Signed sum of four quadrant means, and the Q22 response after scaling.
  localparam int SUM_W     = MEAN_W + 3;
  localparam int SQ2_W     = 17;
  localparam int RESP_W    = SUM_W + SQ2_W;
  localparam int Q14_SHIFT = 14;
  localparam logic signed [SQ2_W-1:0] SQ2_Q14 = 17'sd23170;

  // Fraction division: quotient bits and step counter.
  localparam int QBITS  = 17;
  localparam int STEP_W = $clog2(QBITS);
  localparam int FRAC_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_SET     = 2'd0,
    CFG_EDGE_THRESHOLD = 2'd1,
    CFG_USE_MAGNITUDE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SG_ZERO = 2'd0,
    SG_POS  = 2'd1,
    SG_NEG  = 2'd2
  } sgn_t;

  typedef enum logic [1:0] {
    SC_ONE = 2'd0,
    SC_SQ2 = 2'd1,
    SC_TWO = 2'd2
  } scale_t;

  // A kernel is a sign per quadrant times a common scale.
  typedef struct packed {
    sgn_t   tl;
    sgn_t   tr;
    sgn_t   bl;
    sgn_t   br;
    scale_t scale;
  } kern_t;

  function automatic kern_t kernel_lookup(input logic ten, input logic [KW-1:0] k);
    kern_t r;
    r = '{SG_ZERO, SG_ZERO, SG_ZERO, SG_ZERO, SC_ONE};
    if (ten) begin
      case (int'(k))
        0: r = '{SG_NEG,  SG_POS,  SG_NEG,  SG_POS,  SC_ONE};
        1: r = '{SG_ZERO, SG_POS,  SG_NEG,  SG_ZERO, SC_SQ2};
        2: r = '{SG_POS,  SG_POS,  SG_NEG,  SG_NEG,  SC_ONE};
        3: r = '{SG_POS,  SG_ZERO, SG_ZERO, SG_NEG,  SC_SQ2};
        4: r = '{SG_POS,  SG_NEG,  SG_POS,  SG_NEG,  SC_ONE};
        5: r = '{SG_ZERO, SG_NEG,  SG_POS,  SG_ZERO, SC_SQ2};
        6: r = '{SG_NEG,  SG_NEG,  SG_POS,  SG_POS,  SC_ONE};
        7: r = '{SG_NEG,  SG_ZERO, SG_ZERO, SG_POS,  SC_SQ2};
        8: r = '{SG_POS,  SG_NEG,  SG_NEG,  SG_POS,  SC_TWO};
        9: r = '{SG_NEG,  SG_POS,  SG_POS,  SG_NEG,  SC_TWO};
        default: r = '{SG_ZERO, SG_ZERO, SG_ZERO, SG_ZERO, SC_ONE};
      endcase
    end else begin
      case (int'(k))
        0: r = '{SG_POS,  SG_NEG,  SG_POS,  SG_NEG,  SC_ONE};
        1: r = '{SG_POS,  SG_POS,  SG_NEG,  SG_NEG,  SC_ONE};
        2: r = '{SG_POS,  SG_ZERO, SG_ZERO, SG_NEG,  SC_SQ2};
        3: r = '{SG_ZERO, SG_POS,  SG_NEG,  SG_ZERO, SC_SQ2};
        4: r = '{SG_POS,  SG_NEG,  SG_NEG,  SG_POS,  SC_TWO};
        default: r = '{SG_ZERO, SG_ZERO, SG_ZERO, SG_ZERO, SC_ONE};
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] signed_term(input sgn_t s,
                                                          input logic [MEAN_W-1:0] q);
    logic signed [SUM_W-1:0] qx;
    qx = $signed({{(SUM_W - MEAN_W){1'b0}}, q});
    unique case (s)
      SG_POS:  return qx;
      SG_NEG:  return -qx;
      default: return '0;
    endcase
  endfunction

endpackage

/* src/ehc_if.sv */
// ----------------------------------------------------------------------------
// ehc_if: stream channels of the edge histogram classifier
// Sub-block input channel and bin share output channel, valid/ready.
// ----------------------------------------------------------------------------
interface ehc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ehc_pkg::MEAN_W-1:0]  mean_top_left;
  logic [ehc_pkg::MEAN_W-1:0]  mean_top_right;
  logic [ehc_pkg::MEAN_W-1:0]  mean_bottom_left;
  logic [ehc_pkg::MEAN_W-1:0]  mean_bottom_right;
  logic                        last_in_region;

  modport source (output valid, mean_top_left, mean_top_right, mean_bottom_left,
                  mean_bottom_right, last_in_region, input ready);
  modport sink (input valid, mean_top_left, mean_top_right, mean_bottom_left,
                mean_bottom_right, last_in_region, output ready);
endinterface

interface ehc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ehc_pkg::BIN_IDX_W-1:0] bin_index;
  logic [ehc_pkg::FRAC_W-1:0]    bin_fraction;
  logic                          last_bin;

  modport source (output valid, bin_index, bin_fraction, last_bin, input ready);
  modport sink (input valid, bin_index, bin_fraction, last_bin, output ready);
endinterface

/* src/ehc_ram.sv */
// ----------------------------------------------------------------------------
// ehc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ehc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/edge_histogram_classifier.sv */
// ----------------------------------------------------------------------------
// edge_histogram_classifier: edge kernel classifier with per-region histogram
//
//   channel     dir  beat contents
//   sub_block   in   four quadrant means (8.8), last_in_region
//   bin_share   out  bin_index, bin_fraction (Q16), last_bin
//   cfg_*       in   register write: index, data
//
// One sub-block at a time. A beat sweeps the n = 5 or 10 active kernels,
// one kernel per cycle through the shared response unit, then, if it is
// counted, does a read-modify-write of the bin count RAM. A region end
// handles each bin in turn: RAM read, 17-step restoring division, and the
// output register load. Output stalls hold the divider.
// Reset is synchronous; bin counts come out of reset empty via valid bits.
// ----------------------------------------------------------------------------
module edge_histogram_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ehc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ehc_pkg::CFG_DATA_W-1:0]  cfg_data,
  ehc_in_if.sink                          sub_block,
  ehc_out_if.source                       bin_share
);
  import ehc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_KERN = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_RMW  = 8'b0000_1000,
    S_RDB  = 8'b0001_0000,
    S_LOAD = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_PUT  = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic                    kernel_set;
  logic signed [THR_W-1:0] edge_threshold;
  logic                    use_magnitude;

  // Captured sub-block.
  logic [MEAN_W-1:0] q_tl, q_tr, q_bl, q_br;
  logic              last_r;

  // Kernel sweep.
  logic [KW-1:0]            kidx;
  logic [KW-1:0]            n_active;
  kern_t                    kc;
  logic signed [SUM_W-1:0]  ksum;
  logic signed [RESP_W-1:0] ksum_x;
  logic signed [RESP_W-1:0] kprod;
  logic signed [RESP_W-1:0] resp_next;
  logic signed [RESP_W-1:0] resp;
  logic                     resp_vld;
  logic [BIN_AW-1:0]        resp_idx;
  logic signed [RESP_W-1:0] resp_cmp;
  logic signed [RESP_W-1:0] best;
  logic                     hit;
  logic [BIN_AW-1:0]        win;

  // Bin store.
  logic [MAX_BINS-1:0]   cnt_vld;
  logic                  rd_vld;
  logic [COUNT_BITS-1:0] total;
  logic                  mem_we;
  logic [BIN_AW-1:0]     mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] cnt_read;

  // Region end and division.
  logic [BIN_AW-1:0]            bin;
  logic                         bin_last;
  logic [COUNT_BITS+QBITS-1:0]  dividend;
  logic [COUNT_BITS-1:0]        rem;
  logic [QBITS-1:0]             dvd;
  logic [QBITS-1:0]             quo;
  logic [STEP_W-1:0]            step;
  logic [COUNT_BITS:0]          rem_sh;
  logic                         div_ge;
  logic                         out_load;

  // Output register.
  logic                 out_vld;
  logic [BIN_IDX_W-1:0] out_idx;
  logic [FRAC_W-1:0]    out_frac;
  logic                 out_last;

  assign sub_block.ready      = (state == S_IDLE);
  assign bin_share.valid        = out_vld;
  assign bin_share.bin_index    = out_idx;
  assign bin_share.bin_fraction = out_frac;
  assign bin_share.last_bin     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_set     <= 1'b0;
      edge_threshold <= THR_W'(2816);
      use_magnitude  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KERNEL_SET:     kernel_set     <= cfg_data[0];
        CFG_EDGE_THRESHOLD: edge_threshold <= $signed(cfg_data[THR_W-1:0]);
        CFG_USE_MAGNITUDE:  use_magnitude  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign n_active = kernel_set ? KW'(N_TEN) : KW'(N_FIVE);

  // Response unit: signed sum of the quadrants, then the kernel scale.
  always_comb begin
    kc     = kernel_lookup(kernel_set, kidx);
    ksum   = signed_term(kc.tl, q_tl) + signed_term(kc.tr, q_tr)
           + signed_term(kc.bl, q_bl) + signed_term(kc.br, q_br);
    ksum_x = RESP_W'(ksum);
    kprod  = ksum * SQ2_Q14;
    unique case (kc.scale)
      SC_SQ2:  resp_next = kprod;
      SC_TWO:  resp_next = ksum_x <<< (Q14_SHIFT + 1);
      default: resp_next = ksum_x <<< Q14_SHIFT;
    endcase
  end

  assign resp_cmp = (use_magnitude && resp[RESP_W-1]) ? -resp : resp;

  assign mem_raddr = (state == S_CHK) ? win : bin;
  assign cnt_read  = rd_vld ? mem_rdata : '0;
  assign mem_we    = (state == S_RMW);
  assign mem_wdata = cnt_read + COUNT_BITS'(1);

  ehc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_BINS)
  ) u_bin_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(win),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign bin_last = (KW'(bin) == n_active - KW'(1));
  assign dividend = {{QBITS{1'b0}}, cnt_read} << FRAC_SHIFT
                  | '0;
  assign rem_sh   = {rem, dvd[QBITS-1]};
  assign div_ge   = (rem_sh >= {1'b0, total});
  assign out_load = (state == S_PUT) && (!out_vld || bin_share.ready);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
      cnt_vld <= '0;
      total   <= '0;
    end else begin
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (bin_share.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sub_block.valid) begin
            state <= S_KERN;
          end
        end
        S_KERN: begin
          if (kidx == n_active) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (hit && (total != '1)) begin
            state <= S_RMW;
          end else if (last_r) begin
            state <= S_RDB;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RMW: begin
          cnt_vld[win] <= 1'b1;
          total        <= total + COUNT_BITS'(1);
          state        <= last_r ? S_RDB : S_IDLE;
        end
        S_RDB:  state <= S_LOAD;
        S_LOAD: state <= (total == '0) ? S_PUT : S_DIV;
        S_DIV: begin
          if (step == STEP_W'(QBITS - 1)) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_load) begin
            if (bin_last) begin
              cnt_vld <= '0;
              total   <= '0;
              state   <= S_IDLE;
            end else begin
              state <= S_RDB;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  logic [COUNT_BITS+QBITS-1:0] dividend_r;
  assign dividend_r = dividend + (COUNT_BITS + QBITS)'(total >> 1);

  always_ff @(posedge clk) begin
    rd_vld <= cnt_vld[mem_raddr];
    unique case (state)
      S_IDLE: begin
        if (sub_block.valid) begin
          q_tl     <= sub_block.mean_top_left;
          q_tr     <= sub_block.mean_top_right;
          q_bl     <= sub_block.mean_bottom_left;
          q_br     <= sub_block.mean_bottom_right;
          last_r   <= sub_block.last_in_region;
          kidx     <= '0;
          resp_vld <= 1'b0;
          hit      <= 1'b0;
          best     <= RESP_W'(edge_threshold) <<< Q14_SHIFT;
        end
      end
      S_KERN: begin
        // Compare the previous response while the next one is formed.
        if (resp_vld && (resp_cmp >= best)) begin
          best <= resp_cmp;
          hit  <= 1'b1;
          win  <= resp_idx;
        end
        if (kidx != n_active) begin
          resp     <= resp_next;
          resp_idx <= kidx[BIN_AW-1:0];
          resp_vld <= 1'b1;
          kidx     <= kidx + KW'(1);
        end else begin
          resp_vld <= 1'b0;
        end
      end
      S_CHK: begin
        bin <= '0;
      end
      S_RMW: begin
        bin <= '0;
      end
      S_LOAD: begin
        rem  <= dividend_r[COUNT_BITS+QBITS-1:QBITS];
        dvd  <= dividend_r[QBITS-1:0];
        quo  <= '0;
        step <= '0;
      end
      S_DIV: begin
        rem  <= div_ge ? COUNT_BITS'(rem_sh - {1'b0, total}) : rem_sh[COUNT_BITS-1:0];
        quo  <= {quo[QBITS-2:0], div_ge};
        dvd  <= {dvd[QBITS-2:0], 1'b0};
        step <= step + STEP_W'(1);
      end
      S_PUT: begin
        if (out_load) begin
          out_idx  <= BIN_IDX_W'(bin);
          out_frac <= FRAC_W'(quo);
          out_last <= bin_last;
          bin      <= bin + BIN_AW'(1);
        end
      end
      default: ;
    endcase
  end

  // A region's final beat names the last active bin.
  a_last_bin_index: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_last) |-> (KW'(out_idx) == n_active - KW'(1)))
    else $error("last_bin on a bin other than the last active one");

  // Fractions never exceed one.
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (out_frac <= FRAC_W'(65536)))
    else $error("bin_fraction above 1.0");

  // The division remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < total))
    else $error("divider remainder out of range");

  // An accepted beat always starts the kernel sweep.
  a_accept_kern: assert property (@(posedge clk) disable iff (rst)
    (sub_block.valid && sub_block.ready) |=> (state == S_KERN))
    else $error("accepted beat did not start kernel sweep");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: edge histogram classifier
// Feeds sub-blocks of quadrant means through the input channel and checks
// every bin share beat against a cycle-free predictor of the classifier.
// The run uses both kernel sets, magnitude mode, threshold extremes, a kernel
// set change inside a region and random stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  ONE_TAP         = 16384;
  localparam int  TWO_TAP         = 32768;
  localparam int  SQ2_TAP         = 23170;
  localparam int  COUNT_FULL      = 65535;
  localparam int  SETTLE_CYCLES   = 64;
  localparam int  QUIET_LIMIT     = 4000;
  localparam int  LONG_HOLD       = 400;
  localparam int  PHASE_BLOCKS    = 26;
  localparam int  THR_MIN         = -522240;
  localparam int  THR_MAX         = 522240;

  typedef struct packed {
    logic [15:0] mean_tl;
    logic [15:0] mean_tr;
    logic [15:0] mean_bl;
    logic [15:0] mean_br;
    logic        last_in_region;
  } sub_block_t;

  typedef struct packed {
    logic [3:0]  bin;
    logic [16:0] fraction;
    logic        last;
  } bin_share_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [ehc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ehc_pkg::CFG_DATA_W-1:0] cfg_data;

  ehc_in_if  sub_block ();
  ehc_out_if bin_share ();

  edge_histogram_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sub_block (sub_block),
    .bin_share (bin_share)
  );

  // Predictor state: register copies and the running histogram.
  logic               ten_kernels;
  logic signed [19:0] edge_thr;
  logic               fold_negative;
  int unsigned        bin_tally [10];
  int unsigned        tally_total;

  sub_block_t pending_blocks [$];
  bin_share_t expected_shares [$];

  sub_block_t offered;
  bit         offering;
  int         send_gap;
  int         hold_left;
  bit         hold_req;
  bit         hold_taken;
  bit         idle_on;
  int         quiet_cycles;
  int         mismatches;
  int         blocks_sent;
  int         regions_closed;
  int         shares_checked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Classifies one sub-block, updates the histogram and, on a region end,
  // queues the bin shares the block must report.
  task automatic tally_block(sub_block_t b);
    int         c [4];
    int         k;
    int         nb;
    int         chosen;
    longint     best;
    longint     resp;
    longint     f;
    bin_share_t s;
    nb = ten_kernels ? 10 : 5;
    best = longint'(edge_thr) * 64'sd16384;
    chosen = -1;
    for (k = 0; k < nb; k++) begin
      if (ten_kernels) begin
        case (k)
          0: c = '{-ONE_TAP, ONE_TAP, -ONE_TAP, ONE_TAP};
          1: c = '{0, SQ2_TAP, -SQ2_TAP, 0};
          2: c = '{ONE_TAP, ONE_TAP, -ONE_TAP, -ONE_TAP};
          3: c = '{SQ2_TAP, 0, 0, -SQ2_TAP};
          4: c = '{ONE_TAP, -ONE_TAP, ONE_TAP, -ONE_TAP};
          5: c = '{0, -SQ2_TAP, SQ2_TAP, 0};
          6: c = '{-ONE_TAP, -ONE_TAP, ONE_TAP, ONE_TAP};
          7: c = '{-SQ2_TAP, 0, 0, SQ2_TAP};
          8: c = '{TWO_TAP, -TWO_TAP, -TWO_TAP, TWO_TAP};
          default: c = '{-TWO_TAP, TWO_TAP, TWO_TAP, -TWO_TAP};
        endcase
      end else begin
        case (k)
          0: c = '{ONE_TAP, -ONE_TAP, ONE_TAP, -ONE_TAP};
          1: c = '{ONE_TAP, ONE_TAP, -ONE_TAP, -ONE_TAP};
          2: c = '{SQ2_TAP, 0, 0, -SQ2_TAP};
          3: c = '{0, SQ2_TAP, -SQ2_TAP, 0};
          default: c = '{TWO_TAP, -TWO_TAP, -TWO_TAP, TWO_TAP};
        endcase
      end
      resp = longint'(c[0]) * longint'(b.mean_tl) + longint'(c[1]) * longint'(b.mean_tr)
           + longint'(c[2]) * longint'(b.mean_bl) + longint'(c[3]) * longint'(b.mean_br);
      if (fold_negative && resp < 0) resp = -resp;
      // Ties go to the later kernel.
      if (resp >= best) begin
        best = resp;
        chosen = k;
      end
    end
    if (chosen >= 0 && tally_total < COUNT_FULL) begin
      bin_tally[chosen]++;
      tally_total++;
    end
    if (b.last_in_region) begin
      for (k = 0; k < nb; k++) begin
        f = 0;
        if (tally_total != 0) begin
          f = ((longint'(bin_tally[k]) <<< 16) + longint'(tally_total / 2))
              / longint'(tally_total);
        end
        if (f > 65536) f = 65536;
        s.bin = k[3:0];
        s.fraction = f[16:0];
        s.last = (k == nb - 1);
        expected_shares.push_back(s);
      end
      for (k = 0; k < 10; k++) bin_tally[k] = 0;
      tally_total = 0;
      regions_closed++;
    end
  endtask

  // Sender: one beat at a time, random gaps after each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      sub_block.valid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (sub_block.valid && sub_block.ready) begin
        tally_block(offered);
        blocks_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          sub_block.valid <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
          offered = pending_blocks.pop_front();
          sub_block.mean_top_left     <= offered.mean_tl;
          sub_block.mean_top_right    <= offered.mean_tr;
          sub_block.mean_bottom_left  <= offered.mean_bl;
          sub_block.mean_bottom_right <= offered.mean_br;
          sub_block.last_in_region    <= offered.last_in_region;
          sub_block.valid <= 1'b1;
          offering = 1'b1;
          send_gap = pick_gap();
        end else begin
          sub_block.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each beat, stalls at random, and takes one long hold-off
  // when asked so that the block backs up into its input.
  always @(posedge clk) begin
    bin_share_t want;
    if (rst) begin
      bin_share.ready <= 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
    end else begin
      if (bin_share.valid && bin_share.ready) begin
        shares_checked++;
        if (expected_shares.size() == 0) begin
          mismatches++;
          $display("%0t: bin share beat with nothing expected: got bin %0d fraction %0d last %0b",
                   $time, bin_share.bin_index, bin_share.bin_fraction, bin_share.last_bin);
        end else begin
          want = expected_shares.pop_front();
          if (bin_share.bin_index !== want.bin || bin_share.bin_fraction !== want.fraction ||
              bin_share.last_bin !== want.last) begin
            mismatches++;
            $display("%0t: bin share mismatch: expected bin %0d fraction %0d last %0b,",
                     $time, want.bin, want.fraction, want.last,
                     " got bin %0d fraction %0d last %0b",
                     bin_share.bin_index, bin_share.bin_fraction, bin_share.last_bin);
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left == 0) hold_left = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        bin_share.ready <= 1'b0;
      end else begin
        bin_share.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sub_block.valid && sub_block.ready) || (bin_share.valid && bin_share.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  function automatic sub_block_t random_block(bit last_flag);
    sub_block_t  b;
    int          style;
    logic [15:0] base;
    style = $urandom_range(0, 9);
    base = 16'($urandom);
    b.last_in_region = last_flag;
    if (style < 5) begin
      b.mean_tl = 16'($urandom);
      b.mean_tr = 16'($urandom);
      b.mean_bl = 16'($urandom);
      b.mean_br = 16'($urandom);
    end else if (style < 7) begin
      // Nearly flat blocks keep responses close to the threshold.
      b.mean_tl = base + 16'($urandom_range(0, 2047));
      b.mean_tr = base + 16'($urandom_range(0, 2047));
      b.mean_bl = base + 16'($urandom_range(0, 2047));
      b.mean_br = base + 16'($urandom_range(0, 2047));
    end else if (style == 7) begin
      b.mean_tl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      b.mean_tr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      b.mean_bl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      b.mean_br = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else if (style == 8) begin
      b.mean_tl = $urandom_range(0, 1) ? base : ~base;
      b.mean_tr = $urandom_range(0, 1) ? base : ~base;
      b.mean_bl = $urandom_range(0, 1) ? base : ~base;
      b.mean_br = $urandom_range(0, 1) ? base : ~base;
    end else begin
      b.mean_tl = 16'($urandom_range(0, 255));
      b.mean_tr = 16'($urandom_range(0, 255));
      b.mean_bl = 16'($urandom_range(0, 255));
      b.mean_br = 16'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic add_block(logic [15:0] tl, logic [15:0] tr, logic [15:0] bl,
                           logic [15:0] br, logic last_flag);
    sub_block_t b;
    b.mean_tl = tl;
    b.mean_tr = tr;
    b.mean_bl = bl;
    b.mean_br = br;
    b.last_in_region = last_flag;
    pending_blocks.push_back(b);
  endtask

  // Random regions; the last block queued always closes a region.
  task automatic run_regions(int blocks);
    int len;
    int j;
    while (blocks > 0) begin
      len = $urandom_range(1, 12);
      for (j = 0; j < len; j++) pending_blocks.push_back(random_block(j == len - 1));
      blocks -= len;
    end
  endtask

  // Returns once every block is in, every share is out and the block is quiet.
  task automatic drain();
    do @(posedge clk);
    while (pending_blocks.size() != 0 || offering || expected_shares.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(ehc_pkg::cfg_reg_t idx, logic [19:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ehc_pkg::CFG_KERNEL_SET:     ten_kernels = value[0];
      ehc_pkg::CFG_EDGE_THRESHOLD: edge_thr = value;
      ehc_pkg::CFG_USE_MAGNITUDE:  fold_negative = value[0];
      default: ;
    endcase
  endtask

  // Single-bit registers get random upper bits, which the block must ignore.
  task automatic set_config(bit ten, int thr, bit mag);
    logic [19:0] noise;
    noise = 20'($urandom);
    set_reg(ehc_pkg::CFG_KERNEL_SET, {noise[19:1], ten});
    set_reg(ehc_pkg::CFG_EDGE_THRESHOLD, thr[19:0]);
    noise = 20'($urandom);
    set_reg(ehc_pkg::CFG_USE_MAGNITUDE, {noise[19:1], mag});
  endtask

  initial begin
    int i;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sub_block.valid = 1'b0;
    sub_block.mean_top_left = '0;
    sub_block.mean_top_right = '0;
    sub_block.mean_bottom_left = '0;
    sub_block.mean_bottom_right = '0;
    sub_block.last_in_region = 1'b0;
    bin_share.ready = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    ten_kernels = 1'b0;
    edge_thr = 20'sd2816;
    fold_negative = 1'b0;
    for (i = 0; i < 10; i++) bin_tally[i] = 0;
    tally_total = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings. The first region sees no edge at all, so every share is zero.
    add_block(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_block(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    add_block(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    add_block(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_block(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    add_block(16'hFFFF, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    add_block(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    drain();

    // A response exactly at the threshold still counts.
    set_config(1'b0, 64, 1'b0);
    add_block(16'h0010, 16'h0000, 16'h0000, 16'h0010, 1'b1);
    drain();

    // Negative-only responses count only in magnitude mode.
    set_config(1'b0, 2816, 1'b1);
    add_block(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    add_block(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    drain();

    // Kernel set switched in the middle of a region, both ways.
    set_config(1'b0, 2816, 1'b0);
    add_block(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    pending_blocks.push_back(random_block(1'b0));
    pending_blocks.push_back(random_block(1'b0));
    drain();
    set_reg(ehc_pkg::CFG_KERNEL_SET, 20'd1);
    add_block(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    add_block(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    add_block(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    add_block(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    add_block(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    add_block(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    drain();
    set_reg(ehc_pkg::CFG_KERNEL_SET, 20'd0);
    add_block(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    drain();

    // Ten kernels, with the receiver holding off long enough to back up the input.
    set_config(1'b1, 2816, 1'b0);
    run_regions(PHASE_BLOCKS);
    hold_req = 1'b1;
    drain();

    // A stretch with no idling on either side.
    idle_on = 1'b0;
    set_config(1'b0, 0, 1'b1);
    run_regions(PHASE_BLOCKS);
    drain();
    idle_on = 1'b1;

    set_config(1'b1, THR_MIN, 1'b1);
    run_regions(PHASE_BLOCKS);
    drain();

    // Nothing can reach the largest threshold.
    set_config(1'b1, THR_MAX, 1'b0);
    run_regions(PHASE_BLOCKS);
    drain();

    set_config(1'b0, int'($urandom_range(0, THR_MAX - THR_MIN)) + THR_MIN,
               1'($urandom_range(0, 1)));
    run_regions(PHASE_BLOCKS);
    drain();

    set_config(1'b1, int'($urandom_range(0, 16384)) - 8192, 1'($urandom_range(0, 1)));
    run_regions(PHASE_BLOCKS);
    drain();

    run_regions(12);
    drain();

    $display("run: %0d sub-blocks in %0d regions, %0d bin share beats checked",
             blocks_sent, regions_closed, shares_checked);
    $display("run: both kernel sets, magnitude mode, threshold extremes and a set switch");
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
